>>> rtl/core/json_token_lexer_core_defines.svh
// assertion macros shared by the lexer core
`ifndef JSON_TOKEN_LEXER_CORE_DEFINES_SVH
`define JSON_TOKEN_LEXER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define JTL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define JTL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/jtl_pkg.sv
// types and constants of the json token lexer
package jtl_pkg;

  // token kinds
  localparam logic [3:0] TK_TRUE  = 4'd0;
  localparam logic [3:0] TK_FALSE = 4'd1;
  localparam logic [3:0] TK_STR   = 4'd2;
  localparam logic [3:0] TK_NULL  = 4'd3;
  localparam logic [3:0] TK_NUM   = 4'd4;
  localparam logic [3:0] TK_OCB   = 4'd5;
  localparam logic [3:0] TK_CCB   = 4'd6;
  localparam logic [3:0] TK_OSB   = 4'd7;
  localparam logic [3:0] TK_CSB   = 4'd8;
  localparam logic [3:0] TK_COLON = 4'd9;
  localparam logic [3:0] TK_COMMA = 4'd10;
  localparam logic [3:0] TK_ID    = 4'd11;
  localparam logic [3:0] TK_BAD   = 4'd12;
  localparam logic [3:0] TK_END   = 4'd13;

  // tokens one byte can produce, and the token queue
  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] SAT16 = 16'hFFFF;

  // input beat
  typedef struct packed {
    logic [7:0] byte_in;
    logic       final_byte;
  } jtl_in_t;

  // result beat
  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] token_line;
    logic        syntax_error;
    logic        run_last;
  } jtl_out_t;

  // tokens produced by one byte
  typedef struct packed {
    logic [1:0]                 cnt;
    jtl_out_t [MAX_RES-1:0]     tok;
  } jtl_push_t;

  // queue status
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             room;
  } jtl_fifo_stat_t;

endpackage

>>> rtl/core/jtl_step.sv
// per-byte lexer state and token generation
module jtl_step #(
  parameter int unsigned DOC_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  jtl_pkg::jtl_in_t   beat,
  output jtl_pkg::jtl_push_t push
);
  import jtl_pkg::*;

  localparam logic [15:0] OFF_MAX =
    (DOC_BYTES - 1 > 65535) ? 16'hFFFF : 16'(DOC_BYTES - 1);

  // lexer modes
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_IDENT   = 3'd1;
  localparam logic [2:0] M_STRING  = 3'd2;
  localparam logic [2:0] M_INT     = 3'd3;
  localparam logic [2:0] M_FRAC    = 3'd4;
  localparam logic [2:0] M_EXPSIGN = 3'd5;
  localparam logic [2:0] M_EXPDIG  = 3'd6;
  localparam logic [2:0] M_SKIP    = 3'd7;

  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] off_r, off_nxt;
  logic [15:0] start_r, start_nxt;
  logic [15:0] sline_r, sline_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] len_r, len_nxt;
  logic        bs_r, bs_nxt;
  logic        utf_r, utf_nxt;
  logic [2:0]  kw_r, kw_nxt;
  logic [7:0]  b;
  logic        used;
  logic [1:0]  n;
  jtl_push_t   push_nxt;

  function automatic logic [15:0] inc_sat(logic [15:0] v, logic [15:0] lim);
    return (v >= lim) ? lim : v + 16'd1;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  // narrow the keyword candidates by one more character
  function automatic logic [2:0] kw_next(logic [2:0] kw, logic [15:0] pos,
                                         logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] et, ef, en;
    logic       vt, vf, vn;
    lc = (c inside {["A":"Z"]}) ? (c | 8'h20) : c;
    vt = 1'b1; vf = 1'b1; vn = 1'b1;
    et = 8'h00; ef = 8'h00; en = 8'h00;
    case (pos)
      16'd0: begin et = "t"; ef = "f"; en = "n"; end
      16'd1: begin et = "r"; ef = "a"; en = "u"; end
      16'd2: begin et = "u"; ef = "l"; en = "l"; end
      16'd3: begin et = "e"; ef = "s"; en = "l"; end
      16'd4: begin vt = 1'b0; ef = "e"; vn = 1'b0; end
      default: begin vt = 1'b0; vf = 1'b0; vn = 1'b0; end
    endcase
    return {kw[2] & vn & (lc == en), kw[1] & vf & (lc == ef), kw[0] & vt & (lc == et)};
  endfunction

  function automatic jtl_out_t mk_tok(logic [3:0] kind, logic [15:0] st,
                                      logic [15:0] ln, logic [15:0] li,
                                      logic err, logic last);
    jtl_out_t t;
    t.token_kind   = kind;
    t.token_start  = st;
    t.token_length = ln;
    t.token_line   = li;
    t.syntax_error = err;
    t.run_last     = last;
    return t;
  endfunction

  // identifier or number still open
  function automatic logic pend_has(logic [2:0] m);
    return (m == M_IDENT) || (m >= M_INT && m <= M_EXPDIG);
  endfunction

  // token for the open identifier or number
  function automatic jtl_out_t pend_tok(logic [2:0] m, logic [2:0] kw,
                                        logic [15:0] ln, logic [15:0] st,
                                        logic [15:0] li);
    logic [3:0] kind;
    kind = TK_NUM;
    if (m == M_IDENT) begin
      if (ln == 16'd4 && kw[0]) kind = TK_TRUE;
      else if (ln == 16'd5 && kw[1]) kind = TK_FALSE;
      else if (ln == 16'd4 && kw[2]) kind = TK_NULL;
      else kind = TK_ID;
    end
    return mk_tok(kind, st, ln, li, 1'b0, 1'b0);
  endfunction

  // one byte through the lexer
  always_comb begin
    b         = beat.byte_in;
    mode_nxt  = mode_r;
    off_nxt   = off_r;
    start_nxt = start_r;
    sline_nxt = sline_r;
    line_nxt  = line_r;
    len_nxt   = len_r;
    bs_nxt    = bs_r;
    utf_nxt   = utf_r;
    kw_nxt    = kw_r;
    used      = 1'b0;
    n         = 2'd0;
    push_nxt  = '0;

    // continue the open token
    case (mode_r)
      M_SKIP: used = 1'b1;
      M_STRING: begin
        used = 1'b1;
        if (b == "\"" && !bs_r) begin
          push_nxt.tok[n] = mk_tok(TK_STR, start_r, len_r, sline_r, 1'b0, 1'b0);
          n = n + 2'd1;
          mode_nxt = M_IDLE;
        end else begin
          if (b == 8'h0A) line_nxt = inc_sat(line_r, SAT16);
          bs_nxt  = (b == "\\");
          len_nxt = inc_sat(len_r, SAT16);
        end
      end
      M_IDENT: begin
        if (b >= 8'hC0) begin
          used    = 1'b1;
          utf_nxt = 1'b1;
        end else if (b >= 8'h80) begin
          used = utf_r;
        end else if (is_alpha(b) || is_digit(b) || b == "_") begin
          used    = 1'b1;
          utf_nxt = 1'b0;
        end
        if (used) begin
          kw_nxt  = kw_next(kw_r, len_r, b);
          len_nxt = inc_sat(len_r, SAT16);
        end
      end
      M_INT, M_FRAC: begin
        if (is_digit(b)) begin
          used = 1'b1;
        end else if (b == "." && mode_r == M_INT) begin
          used = 1'b1;
          mode_nxt = M_FRAC;
        end else if (b == "e" || b == "E") begin
          used = 1'b1;
          mode_nxt = M_EXPSIGN;
        end
        if (used) len_nxt = inc_sat(len_r, SAT16);
      end
      M_EXPSIGN: begin
        if (is_digit(b) || b == "+" || b == "-") begin
          used     = 1'b1;
          mode_nxt = M_EXPDIG;
          len_nxt  = inc_sat(len_r, SAT16);
        end
      end
      M_EXPDIG: begin
        if (is_digit(b)) begin
          used    = 1'b1;
          len_nxt = inc_sat(len_r, SAT16);
        end
      end
      default: used = 1'b0;
    endcase

    // close the open token and lex the byte from idle
    if (!used) begin
      if (pend_has(mode_r)) begin
        push_nxt.tok[n] = pend_tok(mode_r, kw_r, len_r, start_r, sline_r);
        n = n + 2'd1;
      end
      mode_nxt = M_IDLE;
      if (b == " " || (b >= 8'h09 && b <= 8'h0D)) begin
        if (b == 8'h0A) line_nxt = inc_sat(line_r, SAT16);
      end else if (b >= 8'hC0 || is_alpha(b) || b == "_") begin
        mode_nxt  = M_IDENT;
        start_nxt = off_r;
        sline_nxt = line_r;
        len_nxt   = 16'd1;
        bs_nxt    = 1'b0;
        utf_nxt   = (b >= 8'hC0);
        kw_nxt    = kw_next(3'b111, 16'd0, b);
      end else if (is_digit(b) || b == "-" || b == "+") begin
        mode_nxt  = M_INT;
        start_nxt = off_r;
        sline_nxt = line_r;
        len_nxt   = 16'd1;
        bs_nxt    = 1'b0;
        utf_nxt   = 1'b0;
        kw_nxt    = 3'b111;
      end else if (b == "\"") begin
        mode_nxt  = M_STRING;
        start_nxt = inc_sat(off_r, OFF_MAX);
        sline_nxt = line_r;
        len_nxt   = 16'd0;
        bs_nxt    = 1'b0;
        utf_nxt   = 1'b0;
        kw_nxt    = 3'b111;
      end else begin
        case (b)
          "{": push_nxt.tok[n] = mk_tok(TK_OCB, off_r, 16'd1, line_r, 1'b0, 1'b0);
          "}": push_nxt.tok[n] = mk_tok(TK_CCB, off_r, 16'd1, line_r, 1'b0, 1'b0);
          "[": push_nxt.tok[n] = mk_tok(TK_OSB, off_r, 16'd1, line_r, 1'b0, 1'b0);
          "]": push_nxt.tok[n] = mk_tok(TK_CSB, off_r, 16'd1, line_r, 1'b0, 1'b0);
          ":": push_nxt.tok[n] = mk_tok(TK_COLON, off_r, 16'd1, line_r, 1'b0, 1'b0);
          ",": push_nxt.tok[n] = mk_tok(TK_COMMA, off_r, 16'd1, line_r, 1'b0, 1'b0);
          default: begin
            push_nxt.tok[n] = mk_tok(TK_BAD, off_r, 16'd1, line_r, 1'b1, 1'b0);
            mode_nxt = M_SKIP;
          end
        endcase
        n = n + 2'd1;
      end
    end

    off_nxt = inc_sat(off_r, OFF_MAX);

    // end of document: flush, end marker, back to reset values
    if (beat.final_byte) begin
      if (mode_nxt == M_STRING) begin
        push_nxt.tok[n] = mk_tok(TK_BAD, start_nxt, len_nxt, sline_nxt, 1'b1, 1'b0);
        n = n + 2'd1;
      end else if (pend_has(mode_nxt)) begin
        push_nxt.tok[n] = pend_tok(mode_nxt, kw_nxt, len_nxt, start_nxt, sline_nxt);
        n = n + 2'd1;
      end
      push_nxt.tok[n] = mk_tok(TK_END, off_nxt, 16'd0, line_nxt, 1'b0, 1'b1);
      n = n + 2'd1;
      mode_nxt  = M_IDLE;
      off_nxt   = 16'd0;
      start_nxt = 16'd0;
      sline_nxt = 16'd1;
      line_nxt  = 16'd1;
      len_nxt   = 16'd0;
      bs_nxt    = 1'b0;
      utf_nxt   = 1'b0;
      kw_nxt    = 3'b111;
    end

    push_nxt.cnt = go ? n : 2'd0;
  end

  assign push = push_nxt;

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      off_r   <= 16'd0;
      start_r <= 16'd0;
      sline_r <= 16'd1;
      line_r  <= 16'd1;
      len_r   <= 16'd0;
      bs_r    <= 1'b0;
      utf_r   <= 1'b0;
      kw_r    <= 3'b111;
    end else if (go) begin
      mode_r  <= mode_nxt;
      off_r   <= off_nxt;
      start_r <= start_nxt;
      sline_r <= sline_nxt;
      line_r  <= line_nxt;
      len_r   <= len_nxt;
      bs_r    <= bs_nxt;
      utf_r   <= utf_nxt;
      kw_r    <= kw_nxt;
    end
  end

endmodule

>>> rtl/core/jtl_fifo.sv
// token queue: up to three writes and one read per cycle
module jtl_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  jtl_pkg::jtl_push_t      push,
  output jtl_pkg::jtl_out_t       out_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output jtl_pkg::jtl_fifo_stat_t stat
);
  import jtl_pkg::*;

  jtl_out_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  // pointer and fill bookkeeping
  assign pop        = out_valid && !out_stall;
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + CNT_W'(push.cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // token storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push.cnt) mem_r[wr_ptr_r + PTR_W'(i)] <= push.tok[i];
    end
  end

  // head of queue drives the result channel
  assign out_valid  = (count_r != '0);
  assign out_data   = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.room  = (count_r <= CNT_W'(FIFO_DEPTH - MAX_RES));

endmodule

>>> rtl/core/json_token_lexer_core.sv
// top level of the byte-serial json token lexer
//
// Input channel in_valid / in_stall / in_data carries one document byte per
// beat, with final_byte marking the last byte of a document. Result channel
// out_valid / out_stall / out_data carries one token per beat: kind, start
// offset, length, line, error flag and end-of-document flag.
// A byte is registered on acceptance and lexed only while the queue has
// room for three tokens; its tokens (zero to three) are written into an
// eight-entry token queue, and the first token of a byte is offered from
// the queue once written.
// Throughput is one byte per cycle while the queue has room. The token queue
// drains one token per cycle while out_stall is low, so a stalled receiver
// fills the queue and then raises in_stall.
// Each document ends with an end-marker token, after which offsets, line
// count and lexer mode return to their reset values.
// Reset (rst_n low, synchronous) empties the input register and the queue
// and puts the lexer at the start of a document.
module json_token_lexer_core #(
  parameter int unsigned DOC_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jtl_pkg::jtl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output jtl_pkg::jtl_out_t out_data
);
  import jtl_pkg::*;
`include "json_token_lexer_core_defines.svh"

  logic           stage_valid_r, stage_valid_nxt;
  jtl_in_t        stage_r;
  logic           go;
  logic           in_take;
  jtl_push_t      push;
  jtl_fifo_stat_t fifo_stat;

  // input register, advanced when the queue can take a full byte's tokens
  assign go       = stage_valid_r && fifo_stat.room;
  assign in_stall = stage_valid_r && !fifo_stat.room;
  assign in_take  = in_valid && !in_stall;
  assign stage_valid_nxt = in_take ? 1'b1 : (go ? 1'b0 : stage_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) stage_r <= in_data;
  end

  jtl_step #(
    .DOC_BYTES(DOC_BYTES)
  ) u_step (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (go),
    .beat (stage_r),
    .push (push)
  );

  jtl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (fifo_stat)
  );

  // checks
  `JTL_ASSERT_IMP(a_fifo_bound, 1'b1, fifo_stat.count <= CNT_W'(FIFO_DEPTH),
                  "token queue overflow")
  `JTL_ASSERT_IMP(a_push_room, push.cnt != 2'd0, go && fifo_stat.room,
                  "tokens written without room")
  `JTL_ASSERT_IMP(a_last_is_end, out_valid,
                  out_data.run_last == (out_data.token_kind == TK_END),
                  "end flag and kind disagree")
  `JTL_ASSERT_IMP(a_err_is_bad, out_valid && out_data.syntax_error,
                  out_data.token_kind == TK_BAD, "error flag on a good token")
  `JTL_ASSERT_NXT(a_empty_stays, fifo_stat.count == '0 && push.cnt == 2'd0, !out_valid,
                  "token from an empty queue")

endmodule
